### src/pibc_pkg.sv
// ---------------------------------------------------------------------------
// pibc_pkg
// Shared types, codes and helpers of the palette icon to bgra converter.
// ---------------------------------------------------------------------------
`default_nettype none

package pibc_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int MID_DEPTH         = 2;
    localparam int OUT_DEPTH         = 4;

    typedef enum logic [1:0] {
        OP_PAL_WRITE = 2'd0,
        OP_START     = 2'd1,
        OP_COLOUR    = 2'd2,
        OP_MASK      = 2'd3
    } op_t;

    localparam logic [1:0] DEPTH_IDX4   = 2'd0;
    localparam logic [1:0] DEPTH_IDX8   = 2'd1;
    localparam logic [1:0] DEPTH_DIRECT = 2'd2;

    localparam logic [1:0] REG_DEPTH_MODE = 2'd0;
    localparam logic [1:0] REG_HALVE_SIZE = 2'd1;
    localparam logic [1:0] REG_WIDTH      = 2'd2;

    localparam logic [1:0] DEPTH_MODE_RST = DEPTH_IDX8;
    localparam logic [7:0] WIDTH_RST      = 8'd32;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] NIBBLE_MASK  = 8'h0F;

    typedef struct packed {
        logic       valid;
        logic [1:0] index;
        logic [7:0] data;
    } cfg_write_t;

    // one request as the back end sees it
    typedef struct packed {
        logic        is_write;
        logic        is_mask;
        logic        direct;
        logic        nibble;
        logic [7:0]  data;
        logic [23:0] bgr;
        logic [7:0]  keep;
        logic [7:0]  col0;
    } job_t;

    typedef struct packed {
        logic        kind;
        logic [23:0] bgr;
        logic [7:0]  alpha;
        logic [7:0]  column;
        logic        last;
    } result_t;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'b000, v[i]};
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### src/palette_icon_to_bgra_converter_core.sv
// ---------------------------------------------------------------------------
// palette_icon_to_bgra_converter_core
// Icon bitmap rows to bgra pixels: palette lookup, 24-bit pass-through, mask
// alpha, optional halving.
// ---------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  input    | push / full               | op, data_byte, entry_blue/green/red
//  result   | empty / pop               | kind, blue, green, red, alpha,
//           |                           | column, last
//  config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
//  one request a cycle is accepted while the request queue has room
//  the back end delivers one pixel result a cycle while the output queue has
//  room, so a mask byte gives up to eight results and a four-bit colour byte
//  up to two
//  reset is asynchronous; the palette is not cleared and needs no sweep
//  a held pop stalls only the back end; the front keeps accepting until
//  the request queue fills
// ---------------------------------------------------------------------------
`default_nettype none

module palette_icon_to_bgra_converter_core
    import pibc_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] op,
    input  wire logic [7:0] data_byte,
    input  wire logic [7:0] entry_blue,
    input  wire logic [7:0] entry_green,
    input  wire logic [7:0] entry_red,
    output logic            empty,
    input  wire logic       pop,
    output logic            kind,
    output logic      [7:0] blue,
    output logic      [7:0] green,
    output logic      [7:0] red,
    output logic      [7:0] alpha,
    output logic      [7:0] column,
    output logic            last,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    cfg_write_t cfg;
    logic       accept;
    logic       job_push;
    job_t       job_in;
    logic       job_valid;
    logic       job_pop;
    job_t       job_head;
    result_t    head;

    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;
    assign accept    = push && !full;

    pibc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .accept      (accept),
        .op          (op),
        .data_byte   (data_byte),
        .entry_blue  (entry_blue),
        .entry_green (entry_green),
        .entry_red   (entry_red),
        .job_push    (job_push),
        .job         (job_in)
    );

    pibc_job_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_in),
        .full  (full),
        .pop   (job_pop),
        .valid (job_valid),
        .rdata (job_head)
    );

    pibc_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_head  (job_head),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    assign kind   = head.kind;
    assign blue   = head.bgr[7:0];
    assign green  = head.bgr[15:8];
    assign red    = head.bgr[23:16];
    assign alpha  = head.alpha;
    assign column = head.column;
    assign last   = head.last;

endmodule

`default_nettype wire

### src/pibc_ram.sv
// ---------------------------------------------------------------------------
// pibc_ram
// Generic single write port, single read port ram with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module pibc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### src/pibc_front.sv
// ---------------------------------------------------------------------------
// pibc_front
// Configuration registers, row counters and request classification.
// ---------------------------------------------------------------------------
`default_nettype none

module pibc_front
    import pibc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_write_t cfg,
    input  wire logic       accept,
    input  wire logic [1:0] op,
    input  wire logic [7:0] data_byte,
    input  wire logic [7:0] entry_blue,
    input  wire logic [7:0] entry_green,
    input  wire logic [7:0] entry_red,
    output logic            job_push,
    output job_t            job
);

    logic [1:0]  depth_mode_reg;
    logic        halve_reg;
    logic [7:0]  width_reg;
    logic [7:0]  src_col_reg, src_col_next;
    logic [7:0]  out_col_reg, out_col_next;
    logic        odd_row_reg, odd_row_next;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] partial_reg, partial_next;

    logic        take;
    logic        clear;
    logic        want_push;
    logic [3:0]  npix;
    logic [7:0]  consumed;
    logic [7:0]  keep;
    logic [8:0]  width9;
    job_t        job_c;

    // classify the request
    always_comb
    begin
        take         = 1'b0;
        clear        = 1'b0;
        npix         = 4'd0;
        phase_next   = phase_reg;
        partial_next = partial_reg;
        job_c        = '0;
        job_c.data   = data_byte;
        job_c.col0   = out_col_reg;
        unique case (op_t'(op))
            OP_PAL_WRITE:
            begin
                job_c.is_write = 1'b1;
                job_c.bgr      = {entry_red, entry_green, entry_blue};
            end
            OP_START:
            begin
                clear = 1'b1;
            end
            OP_COLOUR:
            begin
                unique case (depth_mode_reg)
                    DEPTH_IDX4:
                    begin
                        take         = 1'b1;
                        npix         = 4'd2;
                        job_c.nibble = 1'b1;
                    end
                    DEPTH_IDX8:
                    begin
                        take = 1'b1;
                        npix = 4'd1;
                    end
                    DEPTH_DIRECT:
                    begin
                        if (phase_reg == 2'd0)
                        begin
                            partial_next = {partial_reg[15:8], data_byte};
                            phase_next   = 2'd1;
                        end
                        else if (phase_reg == 2'd1)
                        begin
                            partial_next = {data_byte, partial_reg[7:0]};
                            phase_next   = 2'd2;
                        end
                        else
                        begin
                            take         = 1'b1;
                            npix         = 4'd1;
                            job_c.direct = 1'b1;
                            job_c.bgr    = {data_byte, partial_reg};
                            phase_next   = 2'd0;
                        end
                    end
                    default:
                    begin
                        take = 1'b0;
                    end
                endcase
            end
            OP_MASK:
            begin
                take          = 1'b1;
                npix          = 4'd8;
                job_c.is_mask = 1'b1;
            end
        endcase
    end

    // which of up to eight source pixels are consumed and which are kept
    always_comb
    begin
        logic [8:0] pos;
        pos      = '0;
        width9   = {1'b0, width_reg};
        consumed = '0;
        keep     = '0;
        for (int i = 0; i < 8; i++)
        begin
            pos         = {1'b0, src_col_reg} + 9'(i);
            consumed[i] = take && (4'(i) < npix) && (pos < width9);
            keep[i]     = consumed[i] &&
                          (!halve_reg || (!odd_row_reg && !pos[0] && (pos + 9'd1 < width9)));
        end
    end

    always_comb
    begin
        logic [7:0] sc_adv;
        sc_adv       = src_col_reg + {4'b0000, popcount8(consumed)};
        src_col_next = src_col_reg;
        out_col_next = out_col_reg;
        odd_row_next = odd_row_reg;
        if (clear)
        begin
            src_col_next = '0;
            out_col_next = '0;
            odd_row_next = 1'b0;
        end
        else if (take)
        begin
            if (sc_adv >= width_reg)
            begin
                src_col_next = '0;
                out_col_next = '0;
                odd_row_next = !odd_row_reg;
            end
            else
            begin
                src_col_next = sc_adv;
                out_col_next = out_col_reg + {4'b0000, popcount8(keep)};
            end
        end
    end

    assign want_push = job_c.is_write || (take && (keep != 8'd0));
    assign job_push  = accept && want_push;

    always_comb
    begin
        job      = job_c;
        job.keep = keep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_mode_reg <= DEPTH_MODE_RST;
            halve_reg      <= 1'b0;
            width_reg      <= WIDTH_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DEPTH_MODE: depth_mode_reg <= cfg.data[1:0];
                REG_HALVE_SIZE: halve_reg      <= cfg.data[0];
                REG_WIDTH:      width_reg      <= cfg.data;
                default:        width_reg      <= width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg <= '0;
            out_col_reg <= '0;
            odd_row_reg <= 1'b0;
            phase_reg   <= '0;
            partial_reg <= '0;
        end
        else if (accept)
        begin
            src_col_reg <= src_col_next;
            out_col_reg <= out_col_next;
            odd_row_reg <= odd_row_next;
            phase_reg   <= clear ? 2'd0 : phase_next;
            partial_reg <= clear ? 16'd0 : partial_next;
        end
    end

endmodule

`default_nettype wire

### src/pibc_job_queue.sv
// ---------------------------------------------------------------------------
// pibc_job_queue
// Short request queue between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module pibc_job_queue
    import pibc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t wdata,
    output logic      full,
    input  wire logic pop,
    output logic      valid,
    output job_t      rdata
);

    localparam int PW = (MID_DEPTH > 1) ? $clog2(MID_DEPTH) : 1;
    localparam int CW = $clog2(MID_DEPTH + 1);

    job_t          mem [MID_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(MID_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign full  = (count_reg == CW'(MID_DEPTH));
    assign valid = (count_reg != '0);
    assign rdata = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

### src/pibc_back.sv
// ---------------------------------------------------------------------------
// pibc_back
// Expands requests into pixel results: palette access, mask alpha, output queue.
// ---------------------------------------------------------------------------
`default_nettype none

module pibc_back
    import pibc_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_valid,
    input  wire job_t job_head,
    output logic      job_pop,
    input  wire logic pop,
    output logic      empty,
    output result_t   head
);

    localparam int AW  = $clog2(PALETTE_DEPTH);
    localparam int OPW = $clog2(OUT_DEPTH);
    localparam int OCW = $clog2(OUT_DEPTH + 1);

    logic           cur_valid_reg, cur_valid_next;
    job_t           cur_reg, cur_next;
    logic [7:0]     col_reg, col_next;

    logic           pend_valid_reg;
    result_t        pend_reg, pend_next;
    logic           pend_ram_reg, pend_ram_next;
    logic           pend_black_reg, pend_black_next;

    result_t        out_mem [OUT_DEPTH];
    logic [OPW-1:0] out_wr_reg, out_rd_reg;
    logic [OCW-1:0] out_count_reg, out_count_next;

    logic           credit;
    logic           step;
    logic           issue;
    logic           done;
    logic [2:0]     pick;
    logic [7:0]     sel;
    logic [7:0]     rest;
    logic [7:0]     idx;
    logic           in_range;
    logic           ram_we;
    logic           ram_re;
    logic [AW-1:0]  ram_addr;
    logic [23:0]    ram_rdata;
    result_t        out_wdata;
    logic           out_rd;

    // lowest pending pixel of the current request
    always_comb
    begin
        pick = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (cur_reg.keep[i])
            begin
                pick = 3'(i);
            end
        end
        sel  = 8'd1 << pick;
        rest = cur_reg.keep & ~sel;
    end

    always_comb
    begin
        idx = cur_reg.data;
        if (cur_reg.nibble)
        begin
            idx = (pick == 3'd0) ? (NIBBLE_MASK & (cur_reg.data >> 4))
                                 : (NIBBLE_MASK & cur_reg.data);
        end
        if (cur_reg.is_write)
        begin
            idx = cur_reg.data;
        end
        in_range = ({1'b0, idx} < 9'(PALETTE_DEPTH));
        ram_addr = idx[AW-1:0];
    end

    // an issued pixel always finds room in the output queue
    assign credit = (out_count_reg + OCW'(pend_valid_reg)) < OCW'(OUT_DEPTH);
    assign step   = cur_valid_reg && (cur_reg.is_write || credit);
    assign issue  = step && !cur_reg.is_write;
    assign done   = cur_reg.is_write || (rest == 8'd0);
    assign ram_we = step && cur_reg.is_write && in_range;
    assign ram_re = issue && !cur_reg.is_mask && !cur_reg.direct;

    assign job_pop = job_valid && (!cur_valid_reg || (step && done));

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        col_next       = col_reg;
        if (job_pop)
        begin
            cur_valid_next = 1'b1;
            cur_next       = job_head;
            col_next       = job_head.col0;
        end
        else if (step)
        begin
            cur_next.keep = rest;
            col_next      = col_reg + 8'd1;
            if (done)
            begin
                cur_valid_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        pend_next        = '0;
        pend_next.kind   = cur_reg.is_mask;
        pend_next.bgr    = cur_reg.direct ? cur_reg.bgr : 24'd0;
        pend_next.alpha  = (cur_reg.is_mask && !cur_reg.data[3'd7 - pick]) ? ALPHA_OPAQUE
                                                                            : 8'd0;
        pend_next.column = col_reg;
        pend_next.last   = (rest == 8'd0);
        pend_ram_next    = !cur_reg.is_mask && !cur_reg.direct;
        pend_black_next  = !in_range;
    end

    pibc_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (cur_reg.bgr),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        out_wdata = pend_reg;
        if (pend_ram_reg)
        begin
            out_wdata.bgr = pend_black_reg ? 24'd0 : ram_rdata;
        end
    end

    assign empty  = (out_count_reg == '0);
    assign head   = out_mem[out_rd_reg];
    assign out_rd = pop && !empty;

    always_comb
    begin
        out_count_next = out_count_reg;
        if (pend_valid_reg && !out_rd)
        begin
            out_count_next = out_count_reg + OCW'(1);
        end
        else if (out_rd && !pend_valid_reg)
        begin
            out_count_next = out_count_reg - OCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop || step)
        begin
            cur_reg <= cur_next;
            col_reg <= col_next;
        end
        if (issue)
        begin
            pend_reg       <= pend_next;
            pend_ram_reg   <= pend_ram_next;
            pend_black_reg <= pend_black_next;
        end
        if (pend_valid_reg)
        begin
            out_mem[out_wr_reg] <= out_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_wr_reg     <= '0;
            out_rd_reg     <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            cur_valid_reg  <= cur_valid_next;
            pend_valid_reg <= issue;
            if (pend_valid_reg)
            begin
                out_wr_reg <= (out_wr_reg == OPW'(OUT_DEPTH - 1)) ? '0 : out_wr_reg + OPW'(1);
            end
            if (out_rd)
            begin
                out_rd_reg <= (out_rd_reg == OPW'(OUT_DEPTH - 1)) ? '0 : out_rd_reg + OPW'(1);
            end
            out_count_reg <= out_count_next;
        end
    end

    a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_count_reg <= OCW'(OUT_DEPTH))
        else $error("output queue overfilled");

    a_pend_room: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (out_count_reg < OCW'(OUT_DEPTH)))
        else $error("palette read issued without room in output queue");

    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_valid_reg && !cur_reg.is_write) |-> (cur_reg.keep != 8'd0))
        else $error("pixel request with no pixel left is still active");

    a_issue_order: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && pend_next.last) |=>
            !cur_valid_reg || cur_reg.is_write || (cur_reg.keep != 8'd0))
        else $error("request not retired after its last pixel");

endmodule

`default_nettype wire

### tb/palette_icon_to_bgra_converter_core_tb.sv
// ---------------------------------------------------------------------------
// palette_icon_to_bgra_converter_core_tb
// Drives palette writes, plane starts, colour and mask bytes into the
// converter under all depth modes, with and without halving, at a range of
// row widths. Every accepted request is run through a local copy of the
// conversion, and each popped pixel is checked field by field against the
// oldest pixel still due.

module palette_icon_to_bgra_converter_core_tb;
    import pibc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] DEPTH_UNUSED  = 2'd3;
    localparam int         SETTLE_CYCLES = 64;
    localparam int         RANDOM_ITEMS  = 100;

    typedef struct packed {
        logic       kind;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic [7:0] column;
        logic       last;
    } pixel_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [1:0] op = OP_START;
    logic [7:0] data_byte = '0;
    logic [7:0] entry_blue = '0;
    logic [7:0] entry_green = '0;
    logic [7:0] entry_red = '0;
    logic       empty;
    logic       pop = 1'b0;
    logic       kind;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic [7:0] column;
    logic       last;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = REG_DEPTH_MODE;
    logic [7:0] cfg_data = '0;

    // local copy of the converter state
    logic [23:0] palette_copy [0:255];
    bit          palette_set  [0:255];
    logic [7:0]  palette_used [$];
    int          src_col = 0;
    int          out_col = 0;
    bit          odd_row_q = 1'b0;
    int          phase_q = 0;
    logic [15:0] partial_q = '0;
    logic [1:0]  depth_q = DEPTH_MODE_RST;
    bit          halve_q = 1'b0;
    int          width_q = int'(WIDTH_RST);

    pixel_t      pixels_due [$];
    int          mismatch_count = 0;
    int          random_sent = 0;
    bit          stalls_on = 1'b1;
    int          pop_hold = 0;

    palette_icon_to_bgra_converter_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .op          (op),
        .data_byte   (data_byte),
        .entry_blue  (entry_blue),
        .entry_green (entry_green),
        .entry_red   (entry_red),
        .empty       (empty),
        .pop         (pop),
        .kind        (kind),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .alpha       (alpha),
        .column      (column),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------ prediction

    function automatic bit take_pixel(output logic [7:0] col);
        bit keep;
        keep = 1'b0;
        col = '0;
        if (src_col < width_q)
        begin
            if (halve_q)
                keep = !odd_row_q && (src_col % 2 == 0) && (src_col + 1 < width_q);
            else
                keep = 1'b1;
            if (keep)
            begin
                col = out_col[7:0];
                out_col = (out_col + 1) % 256;
            end
            src_col++;
        end
        return keep;
    endfunction

    function automatic void close_row();
        if (src_col >= width_q)
        begin
            src_col = 0;
            out_col = 0;
            odd_row_q = ~odd_row_q;
        end
    endfunction

    function automatic pixel_t colour_pixel(input logic [23:0] bgr, input logic [7:0] col);
        pixel_t px;
        px = '0;
        px.blue = bgr[7:0];
        px.green = bgr[15:8];
        px.red = bgr[23:16];
        px.column = col;
        return px;
    endfunction

    function automatic void convert_request(input op_t o, input logic [7:0] db,
                                            input logic [23:0] bgr);
        pixel_t     found [$];
        pixel_t     px;
        logic [7:0] col;
        logic [7:0] inv;
        case (o)
            OP_PAL_WRITE:
            begin
                palette_copy[db] = bgr;
                if (!palette_set[db])
                begin
                    palette_set[db] = 1'b1;
                    palette_used.push_back(db);
                end
            end
            OP_START:
            begin
                src_col = 0;
                out_col = 0;
                odd_row_q = 1'b0;
                phase_q = 0;
                partial_q = '0;
            end
            OP_COLOUR:
            begin
                case (depth_q)
                    DEPTH_IDX4:
                    begin
                        if (take_pixel(col))
                            found.push_back(colour_pixel(palette_copy[db[7:4]], col));
                        if (take_pixel(col))
                            found.push_back(colour_pixel(palette_copy[db[3:0]], col));
                        close_row();
                    end
                    DEPTH_IDX8:
                    begin
                        if (take_pixel(col))
                            found.push_back(colour_pixel(palette_copy[db], col));
                        close_row();
                    end
                    DEPTH_DIRECT:
                    begin
                        if (phase_q == 0)
                        begin
                            partial_q = {8'h00, db};
                            phase_q = 1;
                        end
                        else if (phase_q == 1)
                        begin
                            partial_q[15:8] = db;
                            phase_q = 2;
                        end
                        else
                        begin
                            phase_q = 0;
                            if (take_pixel(col))
                                found.push_back(colour_pixel({db, partial_q}, col));
                            close_row();
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                // mask bits are inverted, msb is the leftmost pixel
                inv = ~db;
                for (int i = 7; i >= 0; i--)
                begin
                    if (take_pixel(col))
                    begin
                        px = '0;
                        px.kind = 1'b1;
                        px.alpha = inv[i] ? ALPHA_OPAQUE : 8'h00;
                        px.column = col;
                        found.push_back(px);
                    end
                end
                close_row();
            end
        endcase
        if (found.size() > 0)
        begin
            px = found.pop_back();
            px.last = 1'b1;
            found.push_back(px);
        end
        foreach (found[i])
            pixels_due.push_back(found[i]);
    endfunction

    // -------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : result_check
        pixel_t want;
        if (rst_n && pop && !empty)
        begin
            if (pixels_due.size() == 0)
                report_mismatch("pixel with nothing due, column", int'(column), -1);
            else
            begin
                want = pixels_due.pop_front();
                if (kind !== want.kind)
                    report_mismatch("kind", int'(kind), int'(want.kind));
                if (blue !== want.blue)
                    report_mismatch("blue", int'(blue), int'(want.blue));
                if (green !== want.green)
                    report_mismatch("green", int'(green), int'(want.green));
                if (red !== want.red)
                    report_mismatch("red", int'(red), int'(want.red));
                if (alpha !== want.alpha)
                    report_mismatch("alpha", int'(alpha), int'(want.alpha));
                if (column !== want.column)
                    report_mismatch("column", int'(column), int'(want.column));
                if (last !== want.last)
                    report_mismatch("last", int'(last), int'(want.last));
            end
        end
    end

    // result side back-pressure in bursts of random length
    always @(negedge clk)
    begin
        if (pop_hold > 0)
        begin
            pop <= 1'b0;
            pop_hold <= pop_hold - 1;
        end
        else if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            pop <= 1'b0;
            pop_hold <= $urandom_range(0, 3);
        end
        else
            pop <= 1'b1;
    end

    // ---------------------------------------------------------------- driving

    // called at a falling edge; returns at the falling edge after acceptance
    // with push left high, so the next request can follow without a gap
    task automatic send_item(input op_t o, input logic [7:0] db, input logic [23:0] bgr);
        if (stalls_on && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        push <= 1'b1;
        op <= o;
        data_byte <= db;
        entry_blue <= bgr[7:0];
        entry_green <= bgr[15:8];
        entry_red <= bgr[23:16];
        @(posedge clk);
        while (full)
            @(posedge clk);
        convert_request(o, db, bgr);
        @(negedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge clk);
        // requests that make no pixel may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_DEPTH_MODE: depth_q = val[1:0];
            REG_HALVE_SIZE: halve_q = val[0];
            default:        width_q = int'(val);
        endcase
        @(negedge clk);
    endtask

    task automatic set_config(input logic [1:0] mode, input bit halve, input logic [7:0] width);
        drain();
        write_reg(REG_DEPTH_MODE, {6'd0, mode});
        write_reg(REG_HALVE_SIZE, {7'd0, halve});
        write_reg(REG_WIDTH, width);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_colour_byte();
        // the eight-bit index mode only looks up entries that were written
        if (depth_q == DEPTH_IDX4 || depth_q == DEPTH_DIRECT)
            return 8'($urandom_range(0, 255));
        return palette_used[$urandom_range(0, palette_used.size() - 1)];
    endfunction

    task automatic send_noise();
        op_t o;
        o = op_t'($urandom_range(0, 3));
        case (o)
            OP_PAL_WRITE: send_item(o, 8'($urandom_range(0, 255)), 24'($urandom));
            OP_COLOUR:    send_item(o, pick_colour_byte(), 24'h0);
            default:      send_item(o, 8'($urandom_range(0, 255)), 24'h0);
        endcase
    endtask

    // one plane: a start request, then rows of colour or mask bytes, noise if noisy
    task automatic send_plane(input bit is_mask, input int rows, input bit noisy);
        int per_row;
        if (is_mask)
            per_row = (width_q + 7) / 8;
        else if (depth_q == DEPTH_IDX4)
            per_row = (width_q + 1) / 2;
        else if (depth_q == DEPTH_DIRECT)
            per_row = 3 * width_q;
        else
            per_row = width_q;
        if (per_row == 0)
            per_row = 1;
        send_item(OP_START, 8'($urandom_range(0, 255)), 24'h0);
        for (int n = 0; n < rows * per_row; n++)
        begin
            if (noisy && $urandom_range(0, 24) == 0)
                send_noise();
            if (!(noisy && $urandom_range(0, 24) == 0))
            begin
                if (is_mask)
                    send_item(OP_MASK, 8'($urandom_range(0, 255)), 24'h0);
                else
                    send_item(OP_COLOUR, pick_colour_byte(), 24'h0);
            end
            random_sent++;
        end
    endtask

    // ------------------------------------------------------------------ tests

    task automatic test_palette_fill();
        send_item(OP_PAL_WRITE, 8'd0, 24'h000000);
        for (int i = 1; i < 15; i++)
            send_item(OP_PAL_WRITE, i[7:0], 24'($urandom));
        send_item(OP_PAL_WRITE, 8'd15, 24'hFFFFFF);
        send_item(OP_PAL_WRITE, 8'd128, 24'h000000);
        send_item(OP_PAL_WRITE, 8'd255, 24'hFFFFFF);
        repeat (8)
            send_item(OP_PAL_WRITE, 8'($urandom_range(16, 254)), 24'($urandom));
    endtask

    task automatic test_directed_cases();
        // four-bit, odd width: padding nibble and mask bits past the width
        set_config(DEPTH_IDX4, 1'b0, 8'd3);
        send_item(OP_START, 8'h00, 24'h0);
        send_item(OP_COLOUR, 8'h0F, 24'h0);
        send_item(OP_COLOUR, 8'hF0, 24'h0);
        send_item(OP_MASK, 8'h00, 24'h0);
        send_item(OP_MASK, 8'hFF, 24'h0);
        // eight-bit, extreme indices, one pixel rows
        set_config(DEPTH_IDX8, 1'b0, 8'd1);
        send_item(OP_START, 8'hFF, 24'h0);
        send_item(OP_COLOUR, 8'hFF, 24'h0);
        send_item(OP_COLOUR, 8'h80, 24'h0);
        // direct pixel assembled from three bytes
        set_config(DEPTH_DIRECT, 1'b0, 8'd1);
        send_item(OP_START, 8'h00, 24'h0);
        send_item(OP_COLOUR, 8'h00, 24'h0);
        send_item(OP_COLOUR, 8'hFF, 24'h0);
        send_item(OP_COLOUR, 8'h5A, 24'h0);
        // halving on odd width, odd row dropped, planes mixed
        set_config(DEPTH_IDX8, 1'b1, 8'd3);
        send_item(OP_START, 8'h00, 24'h0);
        send_item(OP_MASK, 8'h55, 24'h0);
        send_item(OP_MASK, 8'hAA, 24'h0);
        send_item(OP_COLOUR, 8'h01, 24'h0);
        // unused depth code: colour bytes change nothing
        set_config(DEPTH_UNUSED, 1'b0, 8'd4);
        send_item(OP_START, 8'h00, 24'h0);
        send_item(OP_COLOUR, 8'h05, 24'h0);
        send_item(OP_MASK, 8'h0F, 24'h0);
        // zero width: every byte closes a row, nothing comes out
        set_config(DEPTH_IDX8, 1'b0, 8'd0);
        send_item(OP_START, 8'h00, 24'h0);
        send_item(OP_COLOUR, 8'h01, 24'h0);
        send_item(OP_MASK, 8'h00, 24'h0);
    endtask

    task automatic test_wide_rows();
        set_config(DEPTH_IDX4, 1'b0, 8'd255);
        send_plane(1'b0, 1, 1'b0);
        send_plane(1'b1, 1, 1'b0);
        set_config(DEPTH_IDX8, 1'b1, 8'd255);
        send_plane(1'b1, 2, 1'b0);
    endtask

    task automatic test_random_planes();
        logic [7:0] width;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            stalls_on = ($urandom_range(0, 3) != 0);
            width = ($urandom_range(0, 7) == 0) ? 8'd1 : 8'($urandom_range(1, 12));
            set_config(2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)), width);
            repeat ($urandom_range(0, 2))
                send_item(OP_PAL_WRITE, 8'($urandom_range(0, 255)), 24'($urandom));
            send_plane(1'b0, $urandom_range(1, 4), 1'b1);
            send_plane(1'b1, $urandom_range(1, 4), 1'b1);
        end
    endtask

    task automatic test_back_to_back();
        stalls_on = 1'b0;
        set_config(DEPTH_IDX4, 1'b0, 8'd9);
        send_plane(1'b0, 3, 1'b0);
        send_plane(1'b1, 3, 1'b0);
        set_config(DEPTH_DIRECT, 1'b1, 8'd5);
        send_plane(1'b0, 2, 1'b0);
        send_plane(1'b1, 2, 1'b0);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_palette_fill();
        test_directed_cases();
        test_wide_rows();
        test_random_planes();
        test_back_to_back();
        drain();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
